@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/mrc_pkg.sv @@
// types, constants and the crc step of the response checker
`default_nettype none
package mrc_pkg;

  typedef enum logic [1:0] {
    MODE_ARM  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_EOF  = 2'd2,
    MODE_NONE = 2'd3
  } mrc_mode_e;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_EOF  = 2'd2
  } mrc_op_e;

  typedef enum logic [1:0] {
    PH_STILL = 2'd0,
    PH_WAIT  = 2'd1,
    PH_RCV   = 2'd2
  } mrc_phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ADDR   = 3'd1,
    ST_EXC    = 3'd2,
    ST_FUNC   = 3'd3,
    ST_CRC    = 3'd4,
    ST_LENGTH = 3'd5,
    ST_ECHO   = 3'd6,
    ST_EMPTY  = 3'd7
  } mrc_status_e;

  typedef struct packed {
    mrc_op_e     op;
    logic [7:0]  server_addr;
    logic [7:0]  func_code;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [7:0]  rx_byte;
  } mrc_item_t;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [7:0] FC_RD_COILS = 8'h01;
  localparam logic [7:0] FC_RD_REGS  = 8'h03;
  localparam logic [7:0] FC_WR_COIL  = 8'h05;
  localparam logic [7:0] FC_WR_REG   = 8'h06;
  localparam logic [7:0] FC_EXC_FLAG = 8'h80;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int WriteFrameLen = 8;
  localparam int MinReadLen    = 4;
  localparam int FirstDataLen  = 5;
  localparam int CountOverhead = 5;

  // one byte of the reflected modbus crc
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mrc_front.sv @@
// front end: takes items, classifies the mode and queues them
`default_nettype none
module mrc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [7:0]        server_addr_i,
  input  wire logic [7:0]        func_code_i,
  input  wire logic [15:0]       word_a_i,
  input  wire logic [15:0]       word_b_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   head_valid_o,
  output mrc_pkg::mrc_item_t     head_o,
  input  wire logic              pop_i
);
  import mrc_pkg::*;

  mrc_item_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  mrc_item_t  item;
  mrc_mode_e  mode;

  assign mode       = mrc_mode_e'(mode_i);
  assign in_ready_o = (cnt_q != 2'd2);
  // the unused mode is taken and dropped here
  assign push       = in_valid_i && in_ready_o && (mode != MODE_NONE);

  always_comb begin
    item.server_addr = server_addr_i;
    item.func_code   = func_code_i;
    item.word_a      = word_a_i;
    item.word_b      = word_b_i;
    item.rx_byte     = rx_byte_i;
    case (mode)
      MODE_ARM:  item.op = OP_ARM;
      MODE_BYTE: item.op = OP_BYTE;
      default:   item.op = OP_EOF;
    endcase
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/mrc_back.sv @@
// back end: frame capture, crc, status checks and the output register
`default_nettype none
module mrc_back #(
  parameter int FRAME_BYTES = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire mrc_pkg::mrc_item_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [7:0]             data_byte_o,
  output logic [2:0]             status_o
);
  import mrc_pkg::*;

  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int CW = (LW > 9) ? LW : 9;

  mrc_phase_e  phase_q, phase_d;
  logic [LW-1:0] len_q, len_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  dly0_q, dly0_d, dly1_q, dly1_d;
  logic [23:0] hdr_q, hdr_d;
  logic [31:0] words_q, words_d;
  logic [7:0]  ex_addr_q, ex_addr_d, ex_fc_q, ex_fc_d;
  logic [15:0] ex_a_q, ex_a_d, ex_b_q, ex_b_d;
  logic        ovf_q, ovf_d;

  logic        out_valid_q, out_valid_d, kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [2:0]  stat_q, stat_d;

  logic        is_rd, is_wr, has_res, out_free, room;
  mrc_status_e st;
  logic        cap_en, cap_fresh;
  logic [LW-1:0] idx;
  logic [23:0] hdr_b;
  logic [31:0] words_b;
  logic [15:0] crc_b;
  logic [7:0]  dly0_b;
  logic [7:0]  r_addr, r_fc, r_cnt;

  assign is_rd  = (ex_fc_q == FC_RD_COILS) || (ex_fc_q == FC_RD_REGS);
  assign is_wr  = (ex_fc_q == FC_WR_COIL) || (ex_fc_q == FC_WR_REG);
  assign room   = (len_q < LW'(FRAME_BYTES));
  assign r_addr = hdr_q[23:16];
  assign r_fc   = hdr_q[15:8];
  assign r_cnt  = hdr_q[7:0];

  // end of frame status, first failing check wins
  always_comb begin
    if (ovf_q || (phase_q != PH_RCV) || (len_q == '0)) begin
      st = ST_EMPTY;
    end else if (is_wr ? (len_q != LW'(WriteFrameLen)) : (len_q < LW'(MinReadLen))) begin
      st = ST_LENGTH;
    end else if (r_addr != ex_addr_q) begin
      st = ST_ADDR;
    end else if (!is_rd && !is_wr) begin
      st = ST_FUNC;
    end else if (r_fc == (ex_fc_q | FC_EXC_FLAG)) begin
      st = ST_EXC;
    end else if (r_fc != ex_fc_q) begin
      st = ST_FUNC;
    end else if (crc_q != 16'h0000) begin
      st = ST_CRC;
    end else if (ex_fc_q == FC_RD_COILS) begin
      st = ((CW'(r_cnt) + CW'(CountOverhead)) != CW'(len_q)) ? ST_LENGTH : ST_OK;
    end else if (ex_fc_q == FC_RD_REGS) begin
      st = ({9'd0, r_cnt} != {ex_b_q, 1'b0}) ? ST_LENGTH : ST_OK;
    end else if (words_q[31:16] != ex_a_q) begin
      st = ST_ECHO;
    end else if (words_q[15:0] != ex_b_q) begin
      st = ST_ECHO;
    end else begin
      st = ST_OK;
    end
  end

  assign has_res = (head_i.op == OP_EOF) ||
                   ((head_i.op == OP_BYTE) && (phase_q == PH_RCV) && room && is_rd &&
                    (len_q >= LW'(FirstDataLen)));
  assign out_free = !out_valid_q || out_ready_i;
  // items without a result go through even while the output is held
  assign pop_o    = head_valid_i && (!has_res || out_free);

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    crc_d     = crc_q;
    dly0_d    = dly0_q;
    dly1_d    = dly1_q;
    hdr_d     = hdr_q;
    words_d   = words_q;
    ex_addr_d = ex_addr_q;
    ex_fc_d   = ex_fc_q;
    ex_a_d    = ex_a_q;
    ex_b_d    = ex_b_q;
    ovf_d     = ovf_q;
    cap_en    = 1'b0;
    cap_fresh = 1'b0;

    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    data_d      = data_q;
    stat_d      = stat_q;

    if (pop_o) begin
      case (head_i.op)
        OP_ARM: begin
          ex_addr_d = head_i.server_addr;
          ex_fc_d   = head_i.func_code;
          ex_a_d    = head_i.word_a;
          ex_b_d    = head_i.word_b;
          len_d     = '0;
          crc_d     = CRC_INIT;
          dly0_d    = '0;
          dly1_d    = '0;
          hdr_d     = '0;
          words_d   = '0;
          ovf_d     = 1'b0;
          phase_d   = PH_WAIT;
        end
        OP_BYTE: begin
          case (phase_q)
            PH_WAIT: begin
              cap_en    = 1'b1;
              cap_fresh = 1'b1;
              phase_d   = PH_RCV;
            end
            PH_RCV: begin
              if (!room) begin
                ovf_d   = 1'b1;
                phase_d = PH_STILL;
              end else begin
                cap_en = 1'b1;
              end
            end
            default: phase_d = PH_WAIT;
          endcase
        end
        default: begin
          phase_d = PH_STILL;
          len_d   = '0;
          crc_d   = CRC_INIT;
          dly0_d  = '0;
          dly1_d  = '0;
          hdr_d   = '0;
          words_d = '0;
          ovf_d   = 1'b0;
        end
      endcase

      if (has_res) begin
        out_valid_d = 1'b1;
        if (head_i.op == OP_EOF) begin
          kind_d = KIND_STATUS;
          data_d = '0;
          stat_d = st;
        end else begin
          kind_d = KIND_DATA;
          data_d = dly1_q;
          stat_d = ST_OK;
        end
      end
    end

    // first byte of a frame starts from a cleared capture
    idx     = cap_fresh ? '0 : len_q;
    hdr_b   = cap_fresh ? '0 : hdr_q;
    words_b = cap_fresh ? '0 : words_q;
    crc_b   = cap_fresh ? CRC_INIT : crc_q;
    dly0_b  = cap_fresh ? '0 : dly0_q;
    if (cap_en) begin
      hdr_d   = hdr_b;
      words_d = words_b;
      if (idx == LW'(0)) hdr_d[23:16] = head_i.rx_byte;
      if (idx == LW'(1)) hdr_d[15:8]  = head_i.rx_byte;
      if (idx == LW'(2)) begin
        hdr_d[7:0]     = head_i.rx_byte;
        words_d[31:24] = head_i.rx_byte;
      end
      if (idx == LW'(3)) words_d[23:16] = head_i.rx_byte;
      if (idx == LW'(4)) words_d[15:8]  = head_i.rx_byte;
      if (idx == LW'(5)) words_d[7:0]   = head_i.rx_byte;
      crc_d  = crc16_byte(crc_b, head_i.rx_byte);
      dly1_d = dly0_b;
      dly0_d = head_i.rx_byte;
      len_d  = idx + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STILL;
      len_q       <= '0;
      crc_q       <= CRC_INIT;
      dly0_q      <= '0;
      dly1_q      <= '0;
      hdr_q       <= '0;
      words_q     <= '0;
      ex_addr_q   <= '0;
      ex_fc_q     <= '0;
      ex_a_q      <= '0;
      ex_b_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      dly0_q      <= dly0_d;
      dly1_q      <= dly1_d;
      hdr_q       <= hdr_d;
      words_q     <= words_d;
      ex_addr_q   <= ex_addr_d;
      ex_fc_q     <= ex_fc_d;
      ex_a_q      <= ex_a_d;
      ex_b_q      <= ex_b_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
    stat_q <= stat_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;
  assign status_o    = stat_q;

endmodule
`default_nettype wire

@@ rtl/modbus_rtu_response_checker.sv @@
// top level of the modbus rtu response checker
//
//  channel | direction | handshake              | fields
//  --------+-----------+------------------------+---------------------------------------
//  in      | in        | in_valid_i/in_ready_o  | mode, server_addr, func_code, word_a/b,
//          |           |                        | rx_byte
//  out     | out       | out_valid_o/out_ready_i| kind, data_byte, status
//
// one item per cycle while the queue has room; the back end retires one queued item each
// cycle, crc step included; results leave through one output register in the cycle
// after the item leaves the queue. a two-entry queue parts the input from the back end;
// only result-bearing items wait on a held output register, others retire regardless.
// reset is asynchronous and needs no clearing pass; ready is high from the first cycle.
`default_nettype none
module modbus_rtu_response_checker #(
  parameter int FRAME_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  server_addr_i,
  input  wire logic [7:0]  func_code_i,
  input  wire logic [15:0] word_a_i,
  input  wire logic [15:0] word_b_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             kind_o,
  output logic [7:0]       data_byte_o,
  output logic [2:0]       status_o
);
  import mrc_pkg::*;

  logic      head_valid;
  mrc_item_t head;
  logic      pop;

  mrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .server_addr_i (server_addr_i),
    .func_code_i   (func_code_i),
    .word_a_i      (word_a_i),
    .word_b_i      (word_b_i),
    .rx_byte_i     (rx_byte_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  mrc_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o)
  );

`include "assert_macros.svh"

  `MRC_ASSERT_NOW(a_pop_needs_item, clk_i, rst_ni, pop, head_valid)
  `MRC_ASSERT_NEXT(a_held_item_stays, clk_i, rst_ni, head_valid && !pop, head_valid)
  `MRC_ASSERT_NOW(a_status_no_data, clk_i, rst_ni, out_valid_o && (kind_o == KIND_STATUS), data_byte_o == 8'h00)
  `MRC_ASSERT_NOW(a_data_no_status, clk_i, rst_ni, out_valid_o && (kind_o == KIND_DATA), status_o == ST_OK)

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the modbus rtu response checker
`timescale 1ns / 100ps

module testbench;
  import mrc_pkg::*;

  localparam int FRAME_MAX   = 256;
  localparam int ITEM_GOAL   = 1150;
  localparam int CALM_TAIL   = 120;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hold;   // sender waits here until every result is in
    mrc_mode_e   mode;
    logic [7:0]  addr;
    logic [7:0]  fc;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [7:0]  rxb;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    mrc_status_e status;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic tail_calm = 1'b0;
  req_t cur = '0;

  wire       in_ready_o;
  wire       out_valid_o;
  wire       kind_o;
  wire [7:0] data_byte_o;
  wire [2:0] status_o;

  req_t       link_items[$];
  res_t       due_results[$];
  logic [7:0] frame_buf[$];

  int n_items = 0;
  int n_accepted = 0;
  int n_issued = 0;
  int n_data = 0;
  int n_frames = 0;
  int n_errors = 0;
  int status_tally[8] = '{default: 0};
  int cycles = 0;
  int gap_left = 0;
  int idle_pct = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int mon_cycles = 0;

  // predicted state of the checker
  mrc_phase_e  rx_state = PH_STILL;
  int          frame_cnt = 0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [7:0]  lag0 = '0;
  logic [7:0]  lag1 = '0;
  logic [23:0] head_bytes = '0;
  logic [31:0] echo_words = '0;
  logic [7:0]  arm_addr = '0;
  logic [7:0]  arm_fc = '0;
  logic [15:0] arm_a = '0;
  logic [15:0] arm_b = '0;
  logic        overran = 1'b0;

  modbus_rtu_response_checker #(
    .FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .mode_i       (cur.mode),
    .server_addr_i(cur.addr),
    .func_code_i  (cur.fc),
    .word_a_i     (cur.wa),
    .word_b_i     (cur.wb),
    .rx_byte_i    (cur.rxb),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bit-serial reflected crc, lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic bit is_write_fc(input logic [7:0] fc);
    return (fc == FC_WR_COIL) || (fc == FC_WR_REG);
  endfunction

  function automatic bit is_read_fc(input logic [7:0] fc);
    return (fc == FC_RD_COILS) || (fc == FC_RD_REGS);
  endfunction

  // overflow is left alone: a byte after overflow starts a frame that stays marked
  task automatic frame_reset();
    frame_cnt  = 0;
    frame_crc  = CRC_INIT;
    lag0       = '0;
    lag1       = '0;
    head_bytes = '0;
    echo_words = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (frame_cnt < 3) head_bytes[23 - 8 * frame_cnt -: 8] = b;
    if (frame_cnt >= 2 && frame_cnt < 6) echo_words[31 - 8 * (frame_cnt - 2) -: 8] = b;
    frame_crc = crc_fold(frame_crc, b);
    lag1 = lag0;
    lag0 = b;
    frame_cnt++;
  endtask

  function automatic mrc_status_e frame_verdict();
    logic [7:0] r_addr;
    logic [7:0] r_fc;
    logic [7:0] r_count;
    r_addr  = head_bytes[23:16];
    r_fc    = head_bytes[15:8];
    r_count = head_bytes[7:0];
    if (overran || rx_state != PH_RCV || frame_cnt == 0) return ST_EMPTY;
    if (is_write_fc(arm_fc)) begin
      if (frame_cnt != WriteFrameLen) return ST_LENGTH;
    end else if (frame_cnt < MinReadLen) begin
      return ST_LENGTH;
    end
    if (r_addr != arm_addr) return ST_ADDR;
    if (!is_read_fc(arm_fc) && !is_write_fc(arm_fc)) return ST_FUNC;
    if (r_fc == (arm_fc | FC_EXC_FLAG)) return ST_EXC;
    if (r_fc != arm_fc) return ST_FUNC;
    if (frame_crc != 16'h0000) return ST_CRC;
    if (arm_fc == FC_RD_COILS)
      return (int'(r_count) + CountOverhead != frame_cnt) ? ST_LENGTH : ST_OK;
    if (arm_fc == FC_RD_REGS)
      return (int'(r_count) != 2 * int'(arm_b)) ? ST_LENGTH : ST_OK;
    if (echo_words[31:16] != arm_a || echo_words[15:0] != arm_b) return ST_ECHO;
    return ST_OK;
  endfunction

  task automatic advance_checker(input req_t r);
    res_t       res;
    logic [7:0] out_lag;
    case (r.mode)
      MODE_ARM: begin
        arm_addr = r.addr;
        arm_fc   = r.fc;
        arm_a    = r.wa;
        arm_b    = r.wb;
        frame_reset();
        overran  = 1'b0;
        rx_state = PH_WAIT;
      end
      MODE_BYTE: begin
        out_lag = lag1;
        if (rx_state == PH_WAIT) begin
          frame_reset();
          take_byte(r.rxb);
          rx_state = PH_RCV;
        end else if (rx_state == PH_RCV) begin
          if (frame_cnt >= FRAME_MAX) begin
            overran  = 1'b1;
            rx_state = PH_STILL;
          end else begin
            take_byte(r.rxb);
            // payload leaves two bytes late so the crc never shows
            if (is_read_fc(arm_fc) && frame_cnt > FirstDataLen) begin
              res.kind   = KIND_DATA;
              res.data   = out_lag;
              res.status = ST_OK;
              due_results.push_back(res);
            end
          end
        end else begin
          rx_state = PH_WAIT;
        end
      end
      MODE_EOF: begin
        res.kind   = KIND_STATUS;
        res.data   = 8'h00;
        res.status = frame_verdict();
        due_results.push_back(res);
        rx_state = PH_STILL;
        frame_reset();
        overran = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic q_item(input mrc_mode_e m, input logic [7:0] sa, input logic [7:0] fc,
                        input logic [15:0] wa, input logic [15:0] wb, input logic [7:0] rb);
    req_t r;
    r.hold = 1'b0;
    r.mode = m;
    r.addr = sa;
    r.fc   = fc;
    r.wa   = wa;
    r.wb   = wb;
    r.rxb  = rb;
    link_items.push_back(r);
    if (m != MODE_NONE) n_items++;
  endtask

  task automatic q_arm(input logic [7:0] sa, input logic [7:0] fc,
                       input logic [15:0] wa, input logic [15:0] wb);
    q_item(MODE_ARM, sa, fc, wa, wb, 8'($urandom));
  endtask

  // unused fields carry junk; the block must ignore them
  task automatic q_rx(input logic [7:0] b);
    q_item(MODE_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  task automatic q_eof();
    q_item(MODE_EOF, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
           8'($urandom));
  endtask

  // appends the crc (low byte first) to frame_buf and sends the whole frame
  task automatic q_frame(input bit crc_good);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc_fold(c, frame_buf[i]);
    if (!crc_good) c = c ^ (16'h0001 << $urandom_range(0, 15));
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    foreach (frame_buf[i]) q_rx(frame_buf[i]);
  endtask

  task automatic q_exchange();
    logic [7:0]  sa;
    logic [7:0]  fc;
    logic [7:0]  rfc;
    logic [15:0] wa;
    logic [15:0] wb;
    int          pick;
    int          n;
    int          k;
    pick = $urandom_range(0, 99);
    if (pick < 25) fc = FC_RD_COILS;
    else if (pick < 50) fc = FC_RD_REGS;
    else if (pick < 70) fc = FC_WR_COIL;
    else if (pick < 90) fc = FC_WR_REG;
    else fc = 8'($urandom);
    sa = 8'($urandom);
    wa = 16'($urandom);
    if (fc == FC_RD_REGS && $urandom_range(0, 9) != 0) wb = 16'($urandom_range(0, 6));
    else wb = 16'($urandom);
    q_arm(sa, fc, wa, wb);

    frame_buf.delete();
    frame_buf.push_back(($urandom_range(0, 11) == 0) ? 8'($urandom) : sa);
    pick = $urandom_range(0, 99);
    if (pick < 8) rfc = fc | FC_EXC_FLAG;
    else if (pick < 14) rfc = 8'($urandom);
    else rfc = fc;
    frame_buf.push_back(rfc);
    if (rfc == (fc | FC_EXC_FLAG)) begin
      frame_buf.push_back(8'($urandom_range(1, 4)));
      // write exceptions must still be full length to reach the code check
      if (is_write_fc(fc)) repeat (3) frame_buf.push_back(8'($urandom));
    end else if (fc == FC_RD_COILS) begin
      n = $urandom_range(0, 12);
      frame_buf.push_back(8'(n));
      repeat (n) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) frame_buf[2] = 8'($urandom);
    end else if (fc == FC_RD_REGS) begin
      n = (wb < 16'd8) ? 2 * int'(wb) : 2 * $urandom_range(0, 6);
      frame_buf.push_back(8'(n));
      repeat (n) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 11) == 0) frame_buf[2] = frame_buf[2] + 8'd2;
    end else if (is_write_fc(fc)) begin
      frame_buf.push_back(wa[15:8]);
      frame_buf.push_back(wa[7:0]);
      frame_buf.push_back(wb[15:8]);
      frame_buf.push_back(wb[7:0]);
      if ($urandom_range(0, 7) == 0) begin
        k = 2 + $urandom_range(0, 3);
        frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else begin
      repeat ($urandom_range(0, 8)) frame_buf.push_back(8'($urandom));
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) frame_buf.delete(frame_buf.size() - 1);
    else if (pick == 1) frame_buf.push_back(8'($urandom));
    q_frame($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 15) == 0)
      q_item(MODE_NONE, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
             8'($urandom));
    // now and then the next arm cuts the frame short
    if ($urandom_range(0, 29) != 0) q_eof();
  endtask

  initial begin : stimulus
    req_t pause;
    int   next_pause;
    bit   full_done;
    bit   over_done;

    // directed: empty frame, ignored item, byte while still, field extremes
    q_eof();
    q_item(MODE_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    q_rx(8'hFF);
    q_rx(8'h00);
    q_eof();
    q_arm(8'hFF, FC_RD_REGS, 16'hFFFF, 16'h0001);
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(FC_RD_REGS);
    frame_buf.push_back(8'h02);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    q_frame(1'b1);
    q_eof();
    q_arm(8'h00, FC_WR_REG, 16'h0000, 16'hFFFF);
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    frame_buf.push_back(FC_WR_REG);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    q_frame(1'b1);
    q_eof();

    pause      = '0;
    pause.hold = 1'b1;
    pause.mode = MODE_NONE;
    link_items.push_back(pause);
    next_pause = n_items + 250;
    full_done  = 1'b0;
    over_done  = 1'b0;
    while (n_items < ITEM_GOAL) begin
      if (!full_done && n_items > 300) begin
        // frame that fills the buffer exactly and is still good
        q_arm(8'h5A, FC_RD_COILS, 16'($urandom), 16'($urandom));
        frame_buf.delete();
        frame_buf.push_back(8'h5A);
        frame_buf.push_back(FC_RD_COILS);
        frame_buf.push_back(8'(FRAME_MAX - CountOverhead));
        repeat (FRAME_MAX - CountOverhead) frame_buf.push_back(8'($urandom));
        q_frame(1'b1);
        q_eof();
        full_done = 1'b1;
      end else if (!over_done && n_items > 600) begin
        q_arm(8'hA5, FC_RD_REGS, 16'($urandom), 16'($urandom));
        frame_buf.delete();
        frame_buf.push_back(8'hA5);
        frame_buf.push_back(FC_RD_REGS);
        repeat (FRAME_MAX) frame_buf.push_back(8'($urandom));
        q_frame(1'b1);
        q_eof();
        over_done = 1'b1;
      end else if ($urandom_range(0, 99) < 75) begin
        q_exchange();
      end else begin
        repeat ($urandom_range(1, 6))
          q_item(mrc_mode_e'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                 16'($urandom), 16'($urandom), 8'($urandom));
      end
      if (n_items >= next_pause) begin
        link_items.push_back(pause);
        next_pause = n_items + 250;
      end
    end
    q_eof();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (link_items.size() != 0 || in_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("checked %0d items in, %0d payload bytes and %0d frame statuses out",
             n_accepted, n_data, n_frames);
    $display("statuses ok/addr/exc/func/crc/len/echo/empty: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5], status_tally[6], status_tally[7]);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    req_t nxt;
    logic go;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      tail_calm <= 1'b0;
      gap_left  = 0;
    end else begin
      go  = 1'b0;
      nxt = cur;
      if (in_valid && in_ready_o) begin
        advance_checker(cur);
        n_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (link_items.size() != 0) begin
          if (link_items[0].hold) begin
            if (due_results.size() == 0) link_items.delete(0);
          end else begin
            nxt = link_items.pop_front();
            go  = 1'b1;
            n_issued++;
            if (n_issued % 80 == 0) begin
              case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 6;
                default: idle_pct = 30;
              endcase
            end
            if (!tail_calm && $urandom_range(0, 99) < idle_pct)
              gap_left = $urandom_range(1, 18);
          end
        end
        in_valid <= go;
        cur      <= nxt;
      end
      tail_calm <= (link_items.size() < CALM_TAIL);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      mon_cycles++;
      if (mon_cycles % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 4;
          default: stall_pct = 20;
        endcase
      end
      if (out_valid_o && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result with none expected: kind %0d data %02h status %0d",
                 kind_o, data_byte_o, status_o);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          if (kind_o !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_o);
            n_errors++;
          end
          if (data_byte_o !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, data_byte_o);
            n_errors++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (want.kind == KIND_DATA) begin
            n_data++;
          end else begin
            n_frames++;
            status_tally[want.status]++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!tail_calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycles, due_results.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
